// ----- src/kdl_pkg.sv -----
// Package for the keypad drawer lock controller.
// Holds the payload, state and configuration types, code constants and sizes.
// No dependencies; used by every module in src.
package kdl_pkg;

  localparam int CODE_DIGITS = 6;
  localparam int ENTRY_W     = 4 * CODE_DIGITS;
  localparam int LEN_W       = $clog2(CODE_DIGITS + 1);

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_LOCK = 2'd1,
    OP_TICK = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    MODE_SELECT  = 3'd0,
    MODE_CODE    = 3'd1,
    MODE_WAIT    = 3'd2,
    MODE_OPEN    = 3'd3,
    MODE_CLOSED  = 3'd4,
    MODE_INVALID = 3'd5,
    MODE_LOCKOUT = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    REP_NONE     = 3'd0,
    REP_CLOSED   = 3'd1,
    REP_STORE    = 3'd2,
    REP_PICKUP   = 3'd3,
    REP_REOPENED = 3'd4,
    REP_ALERT    = 3'd5
  } report_t;

  typedef enum logic [1:0] {
    CFG_MAX_WRONG    = 2'd0,
    CFG_INVALID_HOLD = 2'd1,
    CFG_LOCKOUT_HOLD = 2'd2
  } cfg_idx_t;

  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_A         = 4'd10;
  localparam logic [3:0] KEY_B         = 4'd11;
  localparam logic [3:0] KEY_D         = 4'd13;
  localparam logic [3:0] KEY_STAR      = 4'd14;
  localparam logic [3:0] KEY_HASH      = 4'd15;

  localparam logic [3:0]  WRONG_MAX = 4'hF;
  localparam logic [15:0] HOLD_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] key_code;
    logic       lock_level;
  } kdl_in_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic [2:0] digits_entered;
    logic       unlock_request;
    logic [2:0] report_event;
    logic       tamper_alert;
    logic       screen_changed;
  } kdl_out_t;

  typedef struct packed {
    logic [3:0]  max_wrong_attempts;
    logic [15:0] invalid_hold_ticks;
    logic [15:0] lockout_hold_ticks;
  } kdl_cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [ENTRY_W-1:0] entry_digits;
    logic [LEN_W-1:0]   entry_length;
    logic [ENTRY_W-1:0] saved_code;
    logic               drawer_empty;
    logic               reopen_pending;
    logic [3:0]         wrong_attempts;
    logic               alert_flag;
    logic               lock_seen;
    logic [15:0]        hold_count;
  } kdl_state_t;

  localparam kdl_cfg_t CFG_RESET = '{
    max_wrong_attempts: 4'd3,
    invalid_hold_ticks: 16'd3,
    lockout_hold_ticks: 16'd60
  };

  localparam kdl_state_t ST_RESET = '{
    mode:           MODE_SELECT,
    entry_digits:   '0,
    entry_length:   '0,
    saved_code:     '0,
    drawer_empty:   1'b1,
    reopen_pending: 1'b0,
    wrong_attempts: 4'd0,
    alert_flag:     1'b0,
    lock_seen:      1'b0,
    hold_count:     16'd0
  };

endpackage

// ----- src/kdl_cfg_regs.sv -----
// Configuration register file: attempt limit and the two hold times.
// Depends on kdl_pkg.
module kdl_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output kdl_pkg::kdl_cfg_t cfg_q
);

  kdl_pkg::kdl_cfg_t cfg_r;
  kdl_pkg::kdl_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_q     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (kdl_pkg::cfg_idx_t'(cfg_index))
        kdl_pkg::CFG_MAX_WRONG:    cfg_nxt.max_wrong_attempts = cfg_data[3:0];
        kdl_pkg::CFG_INVALID_HOLD: cfg_nxt.invalid_hold_ticks = cfg_data;
        kdl_pkg::CFG_LOCKOUT_HOLD: cfg_nxt.lockout_hold_ticks = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= kdl_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- src/kdl_step.sv -----
// Per-request decision logic: next controller state and the result fields.
// Purely combinational; depends on kdl_pkg.
module kdl_step (
  input  kdl_pkg::kdl_state_t st_cur,
  input  kdl_pkg::kdl_cfg_t   cfg,
  input  kdl_pkg::kdl_in_t    req,
  output kdl_pkg::kdl_state_t st_nxt,
  output kdl_pkg::kdl_out_t   res
);

  logic        entry_full;
  logic        wrong_code;
  logic        lock_edge;
  logic [15:0] hold_inc;
  logic        unlock;
  kdl_pkg::report_t rep;

  assign entry_full = (st_cur.entry_length == kdl_pkg::LEN_W'(kdl_pkg::CODE_DIGITS));
  assign wrong_code = !st_cur.drawer_empty && (st_cur.entry_digits != st_cur.saved_code);
  assign lock_edge  = (req.lock_level != st_cur.lock_seen);
  assign hold_inc   = (st_cur.hold_count == kdl_pkg::HOLD_MAX) ? st_cur.hold_count
                                                                : st_cur.hold_count + 16'd1;

  // next state
  always_comb begin
    st_nxt = st_cur;
    case (kdl_pkg::opcode_t'(req.opcode))
      kdl_pkg::OP_KEY: begin
        case (st_cur.mode)
          kdl_pkg::MODE_SELECT: begin
            if (req.key_code == kdl_pkg::KEY_A) st_nxt.mode = kdl_pkg::MODE_CODE;
          end
          kdl_pkg::MODE_CODE: begin
            if (req.key_code <= kdl_pkg::KEY_DIGIT_MAX) begin
              if (!entry_full) begin
                for (int i = 0; i < kdl_pkg::CODE_DIGITS; i++) begin
                  if (st_cur.entry_length == kdl_pkg::LEN_W'(i))
                    st_nxt.entry_digits[4*i +: 4] = req.key_code;
                end
                st_nxt.entry_length = st_cur.entry_length + kdl_pkg::LEN_W'(1);
              end
            end else if (req.key_code == kdl_pkg::KEY_D) begin
              if (st_cur.entry_length != '0) begin
                st_nxt.entry_length = st_cur.entry_length - kdl_pkg::LEN_W'(1);
                for (int i = 0; i < kdl_pkg::CODE_DIGITS; i++) begin
                  if (st_nxt.entry_length == kdl_pkg::LEN_W'(i))
                    st_nxt.entry_digits[4*i +: 4] = 4'd0;
                end
              end
            end else if (req.key_code == kdl_pkg::KEY_STAR) begin
              st_nxt.entry_digits = '0;
              st_nxt.entry_length = '0;
              st_nxt.mode         = kdl_pkg::MODE_SELECT;
            end else if (req.key_code == kdl_pkg::KEY_HASH && entry_full) begin
              if (wrong_code) begin
                if (st_cur.wrong_attempts != kdl_pkg::WRONG_MAX)
                  st_nxt.wrong_attempts = st_cur.wrong_attempts + 4'd1;
                st_nxt.mode       = kdl_pkg::MODE_INVALID;
                st_nxt.hold_count = 16'd0;
              end else begin
                st_nxt.mode = kdl_pkg::MODE_WAIT;
                if (st_cur.reopen_pending) begin
                  st_nxt.reopen_pending = 1'b0;
                end else if (st_cur.drawer_empty) begin
                  st_nxt.drawer_empty = 1'b0;
                  st_nxt.saved_code   = st_cur.entry_digits;
                end else begin
                  st_nxt.drawer_empty   = 1'b1;
                  st_nxt.wrong_attempts = 4'd0;
                end
              end
            end
          end
          kdl_pkg::MODE_CLOSED: begin
            if (req.key_code == kdl_pkg::KEY_A) begin
              st_nxt.mode = kdl_pkg::MODE_SELECT;
            end else if (req.key_code == kdl_pkg::KEY_B) begin
              // reopen is reported here; reopen_pending is cleared on this wait entry
              st_nxt.mode           = kdl_pkg::MODE_WAIT;
              st_nxt.reopen_pending = 1'b0;
            end
          end
          default: ;
        endcase
      end
      kdl_pkg::OP_LOCK: begin
        if (lock_edge) begin
          st_nxt.lock_seen = req.lock_level;
          if (st_cur.mode != kdl_pkg::MODE_OPEN && st_cur.mode != kdl_pkg::MODE_WAIT)
            st_nxt.alert_flag = 1'b1;
          if (st_cur.mode == kdl_pkg::MODE_WAIT && req.lock_level) begin
            st_nxt.entry_digits = '0;
            st_nxt.entry_length = '0;
            st_nxt.mode         = kdl_pkg::MODE_OPEN;
          end else if (st_cur.mode == kdl_pkg::MODE_OPEN && !req.lock_level) begin
            st_nxt.mode = kdl_pkg::MODE_CLOSED;
          end
        end
      end
      kdl_pkg::OP_TICK: begin
        if (st_cur.mode == kdl_pkg::MODE_INVALID) begin
          st_nxt.hold_count = hold_inc;
          if (hold_inc >= cfg.invalid_hold_ticks) begin
            st_nxt.entry_digits = '0;
            st_nxt.entry_length = '0;
            st_nxt.hold_count   = 16'd0;
            st_nxt.mode = (st_cur.wrong_attempts >= cfg.max_wrong_attempts)
                          ? kdl_pkg::MODE_LOCKOUT : kdl_pkg::MODE_CODE;
          end
        end else if (st_cur.mode == kdl_pkg::MODE_LOCKOUT) begin
          st_nxt.hold_count = hold_inc;
          if (hold_inc >= cfg.lockout_hold_ticks) begin
            st_nxt.hold_count     = 16'd0;
            st_nxt.wrong_attempts = 4'd0;
            st_nxt.mode           = kdl_pkg::MODE_SELECT;
          end
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    unlock = 1'b0;
    rep    = kdl_pkg::REP_NONE;
    case (kdl_pkg::opcode_t'(req.opcode))
      kdl_pkg::OP_KEY: begin
        if (st_cur.mode == kdl_pkg::MODE_CODE && req.key_code == kdl_pkg::KEY_HASH &&
            entry_full && !wrong_code) begin
          unlock = 1'b1;
          if (st_cur.reopen_pending)    rep = kdl_pkg::REP_REOPENED;
          else if (st_cur.drawer_empty) rep = kdl_pkg::REP_STORE;
          else                          rep = kdl_pkg::REP_PICKUP;
        end else if (st_cur.mode == kdl_pkg::MODE_CLOSED &&
                     req.key_code == kdl_pkg::KEY_B) begin
          unlock = 1'b1;
          rep    = kdl_pkg::REP_REOPENED;
        end
      end
      kdl_pkg::OP_LOCK: begin
        if (lock_edge) begin
          if (st_cur.mode != kdl_pkg::MODE_OPEN && st_cur.mode != kdl_pkg::MODE_WAIT &&
              !st_cur.alert_flag)
            rep = kdl_pkg::REP_ALERT;
          else if (st_cur.mode == kdl_pkg::MODE_OPEN && !req.lock_level)
            rep = kdl_pkg::REP_CLOSED;
        end
      end
      default: ;
    endcase

    res.mode_now       = st_nxt.mode;
    res.digits_entered = 3'(st_nxt.entry_length);
    res.unlock_request = unlock;
    res.report_event   = rep;
    res.tamper_alert   = st_nxt.alert_flag;
    res.screen_changed = (st_nxt.mode != st_cur.mode) ||
                         (st_nxt.entry_length != st_cur.entry_length);
  end

endmodule

// ----- src/keypad_drawer_lock_controller_core.sv -----
// Top level of the keypad drawer lock controller.
// Instantiates kdl_cfg_regs and kdl_step; uses kdl_pkg.
//
// Usage:
//   in_*  : one request per event (keypad press, lock sensor change, tick),
//           valid/ready handshake, payload kdl_pkg::kdl_in_t.
//   out_* : exactly one result per request, in order, payload kdl_pkg::kdl_out_t.
//   cfg_* : register writes (0 max wrong attempts, 1 invalid hold,
//           2 lockout hold); cfg_ready is always high. Write only while idle.
// Path: an accepted request is held in the input register; its result is
//   then registered in the output register when the output can take it.
// Throughput: one request per cycle unless the output stalls; each state update
//   is one pass of compare/update logic between the input and output registers.
// Reset (rst_n low, synchronous): pipeline empties, mode returns to select,
//   the drawer reads empty, counters and the tamper alert clear, registers
//   take their defaults.
// Stall: while out_ready is low the result holds; one more request can wait
//   in the input register, after which in_ready drops.
module keypad_drawer_lock_controller_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kdl_pkg::kdl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kdl_pkg::kdl_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  logic                s1_valid_r;
  kdl_pkg::kdl_in_t    s1_data_r;
  logic                out_valid_r;
  kdl_pkg::kdl_out_t   out_data_r;
  kdl_pkg::kdl_state_t st_r;
  kdl_pkg::kdl_state_t st_nxt;
  kdl_pkg::kdl_out_t   res_nxt;
  kdl_pkg::kdl_cfg_t   cfg;
  logic                advance;

  kdl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_q     (cfg)
  );

  kdl_step u_step (
    .st_cur (st_r),
    .cfg    (cfg),
    .req    (s1_data_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= kdl_pkg::ST_RESET;
    end else begin
      if (in_valid && in_ready) s1_valid_r <= 1'b1;
      else if (advance)         s1_valid_r <= 1'b0;
      if (advance)              out_valid_r <= 1'b1;
      else if (out_ready)       out_valid_r <= 1'b0;
      if (advance)              st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r  <= in_data;
    if (advance)              out_data_r <= res_nxt;
  end

  a_unlock_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.unlock_request |->
      out_data_r.mode_now == kdl_pkg::MODE_WAIT)
    else $error("unlock request outside wait mode");

  a_alert_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.alert_flag |=> st_r.alert_flag)
    else $error("tamper alert cleared");

  a_alert_report_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.report_event == kdl_pkg::REP_ALERT |->
      out_data_r.tamper_alert)
    else $error("alert report without tamper flag");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.entry_length <= kdl_pkg::LEN_W'(kdl_pkg::CODE_DIGITS))
    else $error("entry length out of range");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty input register");

endmodule
